// ===== rtl/core/u8d_pkg.sv =====
// u8d_pkg: widths, lead byte code ranges and payload masks for the UTF-8
// stream decoder. No dependencies; used by the channel interfaces and the core.
package u8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 31;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned IDX_W  = 16;   // width of reported index/offset fields

	// lead byte ranges, original six-byte form
	localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF7;
	localparam logic [BYTE_W-1:0] LEAD5_LO  = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD5_HI  = 8'hFB;
	localparam logic [BYTE_W-1:0] LEAD6_LO  = 8'hFC;
	localparam logic [BYTE_W-1:0] LEAD6_HI  = 8'hFD;

	// payload masks per length
	localparam logic [BYTE_W-1:0] MASK1    = 8'h7F;
	localparam logic [BYTE_W-1:0] MASK2    = 8'h1F;
	localparam logic [BYTE_W-1:0] MASK3    = 8'h0F;
	localparam logic [BYTE_W-1:0] MASK4    = 8'h07;
	localparam logic [BYTE_W-1:0] MASK5    = 8'h03;
	localparam logic [BYTE_W-1:0] MASK6    = 8'h01;
	localparam logic [BYTE_W-1:0] MASK_BAD = 8'hFF;

	localparam int unsigned CONT_BITS = 6;  // payload bits per continuation byte

endpackage

// ===== rtl/core/u8d_if.sv =====
// u8d_if: valid/ready channel interfaces for the decoder, byte side and
// character side. Depends on u8d_pkg for field widths.

interface u8d_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u8d_pkg::BYTE_W-1:0]    byte_in;
	logic                          first_byte;
	logic                          last_byte;

	modport source (output valid, output byte_in, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input byte_in, input first_byte, input last_byte,
		output ready);
endinterface

interface u8d_char_if;
	logic                          valid;
	logic                          ready;
	logic [u8d_pkg::CP_W-1:0]      code_point;
	logic [u8d_pkg::LEN_W-1:0]     byte_count;
	logic [u8d_pkg::IDX_W-1:0]     char_index;
	logic [u8d_pkg::IDX_W-1:0]     byte_offset;
	logic                          bad_lead;
	logic                          cut_short;

	modport source (output valid, output code_point, output byte_count,
		output char_index, output byte_offset, output bad_lead, output cut_short,
		input ready);
	modport sink (input valid, input code_point, input byte_count,
		input char_index, input byte_offset, input bad_lead, input cut_short,
		output ready);
endinterface

// ===== rtl/core/utf8_stream_decoder_core.sv =====
// utf8_stream_decoder_core: streaming decoder for six-byte UTF-8, one byte
// per word in, one character per word out. Depends on u8d_pkg and u8d_if.
//
//   channel     | dir | word                                   | handshake
//   ------------+-----+----------------------------------------+-------------
//   byte_chan   | in  | byte_in, first_byte, last_byte         | valid/ready
//   char_chan   | out | code_point, byte_count, char_index,    | valid/ready
//               |     | byte_offset, bad_lead, cut_short       |
//
// Flow: one byte word per clock while byte_chan.ready is high. A completed
//   character appears on char_chan the cycle after its final byte is accepted.
// The decode state update and the result are a single pass of shift/mask
//   logic between the state registers and the result register.
// Reset: arst_n clears the decode state, both counts and the result valid.
// Stalls: byte_chan.ready drops only while a result is held and char_chan
//   is not ready; bytes that complete no character flow freely otherwise.
module utf8_stream_decoder_core #(
	parameter int unsigned INDEX_WIDTH = 16   // 8..32, saturating count width
) (
	input  logic          clk,
	input  logic          arst_n,
	u8d_byte_if.sink      byte_chan,
	u8d_char_if.source    char_chan
);

	localparam int unsigned CP_W  = u8d_pkg::CP_W;
	localparam int unsigned LEN_W = u8d_pkg::LEN_W;
	localparam int unsigned IDX_W = u8d_pkg::IDX_W;
	localparam int unsigned CB    = u8d_pkg::CONT_BITS;

	// decode state
	logic [CP_W-1:0]        acc_q;
	logic [LEN_W-1:0]       left_q;      // continuation bytes still expected
	logic [LEN_W-1:0]       seq_len_q;
	logic [INDEX_WIDTH-1:0] char_cnt_q;
	logic [INDEX_WIDTH-1:0] byte_pos_q;
	logic [INDEX_WIDTH-1:0] start_off_q;

	// result register
	logic                   out_vld_q;
	logic [CP_W-1:0]        out_cp_q;
	logic [LEN_W-1:0]       out_len_q;
	logic [IDX_W-1:0]       out_idx_q;
	logic [IDX_W-1:0]       out_off_q;
	logic                   out_bad_q;
	logic                   out_cut_q;

	logic take;

	// next-state / result from the decode pass
	logic [CP_W-1:0]        nx_acc;
	logic [LEN_W-1:0]       nx_left;
	logic [LEN_W-1:0]       nx_len;
	logic [INDEX_WIDTH-1:0] nx_cc;
	logic [INDEX_WIDTH-1:0] nx_bp;
	logic [INDEX_WIDTH-1:0] nx_so;

	logic [LEN_W-1:0]       w_left;
	logic [LEN_W-1:0]       w_len;
	logic [CP_W-1:0]        w_acc;
	logic [INDEX_WIDTH-1:0] w_cc;
	logic [INDEX_WIDTH-1:0] w_bp;

	logic [LEN_W-1:0]       lead_len;
	logic [7:0]             lead_mask;
	logic                   lead_bad;

	logic                   em;
	logic [CP_W-1:0]        em_cp;
	logic [LEN_W-1:0]       em_len;
	logic                   em_bad;
	logic                   em_cut;
	logic [IDX_W-1:0]       em_idx;
	logic [IDX_W-1:0]       em_off;
	logic [31:0]            cc_ext;
	logic [31:0]            so_ext;

	assign take            = byte_chan.valid & byte_chan.ready;
	assign byte_chan.ready = ~out_vld_q | char_chan.ready;

	// lead byte classification
	always_comb begin
		lead_bad  = 1'b0;
		lead_len  = LEN_W'(1);
		lead_mask = u8d_pkg::MASK_BAD;
		if (byte_chan.byte_in <= u8d_pkg::ASCII_MAX) begin
			lead_mask = u8d_pkg::MASK1;
		end else if (byte_chan.byte_in inside {[u8d_pkg::LEAD2_LO:u8d_pkg::LEAD2_HI]}) begin
			lead_len  = LEN_W'(2);
			lead_mask = u8d_pkg::MASK2;
		end else if (byte_chan.byte_in inside {[u8d_pkg::LEAD3_LO:u8d_pkg::LEAD3_HI]}) begin
			lead_len  = LEN_W'(3);
			lead_mask = u8d_pkg::MASK3;
		end else if (byte_chan.byte_in inside {[u8d_pkg::LEAD4_LO:u8d_pkg::LEAD4_HI]}) begin
			lead_len  = LEN_W'(4);
			lead_mask = u8d_pkg::MASK4;
		end else if (byte_chan.byte_in inside {[u8d_pkg::LEAD5_LO:u8d_pkg::LEAD5_HI]}) begin
			lead_len  = LEN_W'(5);
			lead_mask = u8d_pkg::MASK5;
		end else if (byte_chan.byte_in inside {[u8d_pkg::LEAD6_LO:u8d_pkg::LEAD6_HI]}) begin
			lead_len  = LEN_W'(6);
			lead_mask = u8d_pkg::MASK6;
		end else begin
			lead_bad = 1'b1;   // stray continuation, FE or FF: pass byte through
		end
	end

	always_comb begin
		// a first-byte mark drops any pending character and restarts counts
		w_left = byte_chan.first_byte ? '0 : left_q;
		w_len  = byte_chan.first_byte ? '0 : seq_len_q;
		w_acc  = byte_chan.first_byte ? '0 : acc_q;
		w_cc   = byte_chan.first_byte ? '0 : char_cnt_q;
		w_bp   = byte_chan.first_byte ? '0 : byte_pos_q;

		nx_so  = start_off_q;
		em     = 1'b0;
		em_bad = 1'b0;
		em_cut = 1'b0;

		if (w_left == '0) begin
			nx_so   = w_bp;
			nx_acc  = CP_W'(byte_chan.byte_in & lead_mask);
			nx_len  = lead_len;
			em_len  = lead_len;
			em_cp   = nx_acc;
			if (lead_len == LEN_W'(1)) begin
				nx_left = '0;
				em      = 1'b1;
				em_bad  = lead_bad;
			end else begin
				nx_left = lead_len - LEN_W'(1);
			end
		end else begin
			nx_acc  = {w_acc[CP_W-CB-1:0], byte_chan.byte_in[CB-1:0]};
			nx_left = w_left - LEN_W'(1);
			nx_len  = w_len;
			em_len  = w_len;
			em_cp   = nx_acc;
			em      = (nx_left == '0);
		end

		nx_cc = w_cc;
		if (em && (w_cc != '1)) begin
			nx_cc = w_cc + INDEX_WIDTH'(1);
		end
		nx_bp = (w_bp == '1) ? w_bp : w_bp + INDEX_WIDTH'(1);

		// end of string: flush an unfinished character, low bits zero
		if (byte_chan.last_byte) begin
			if (nx_left != '0) begin
				em     = 1'b1;
				em_cut = 1'b1;
				em_len = nx_len;
				case (nx_left)
					LEN_W'(1): em_cp = nx_acc << CB;
					LEN_W'(2): em_cp = nx_acc << (2 * CB);
					LEN_W'(3): em_cp = nx_acc << (3 * CB);
					LEN_W'(4): em_cp = nx_acc << (4 * CB);
					LEN_W'(5): em_cp = nx_acc << (5 * CB);
					default:   em_cp = '0;
				endcase
			end
			nx_acc  = '0;
			nx_left = '0;
			nx_len  = '0;
			nx_cc   = '0;
			nx_bp   = '0;
			nx_so   = '0;
		end

		// only one character per byte, so the index is always the pre-increment count
		cc_ext = 32'(w_cc);
		so_ext = 32'(byte_chan.last_byte ? (w_left == '0 ? w_bp : start_off_q)
			: nx_so);
		em_idx = cc_ext[IDX_W-1:0];
		em_off = so_ext[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			left_q      <= '0;
			seq_len_q   <= '0;
			char_cnt_q  <= '0;
			byte_pos_q  <= '0;
			start_off_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (take) begin
				acc_q       <= nx_acc;
				left_q      <= nx_left;
				seq_len_q   <= nx_len;
				char_cnt_q  <= nx_cc;
				byte_pos_q  <= nx_bp;
				start_off_q <= nx_so;
			end
			if (take && em) begin
				out_vld_q <= 1'b1;
			end else if (char_chan.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only with a new character
	always_ff @(posedge clk) begin
		if (take && em) begin
			out_cp_q  <= em_cp;
			out_len_q <= em_len;
			out_idx_q <= em_idx;
			out_off_q <= em_off;
			out_bad_q <= em_bad;
			out_cut_q <= em_cut;
		end
	end

	assign char_chan.valid       = out_vld_q;
	assign char_chan.code_point  = out_cp_q;
	assign char_chan.byte_count  = out_len_q;
	assign char_chan.char_index  = out_idx_q;
	assign char_chan.byte_offset = out_off_q;
	assign char_chan.bad_lead    = out_bad_q;
	assign char_chan.cut_short   = out_cut_q;

	// pending continuations never reach the announced length
	a_left_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q != '0) |-> (left_q < seq_len_q))
		else $error("continuation count not below sequence length");

	// a bad lead is always a single-byte, complete character
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_bad_q) |-> (out_len_q == LEN_W'(1) && !out_cut_q))
		else $error("bad lead with length other than one or cut short");

	// a cut character was announced as a multi-byte sequence
	a_cut_multi: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_cut_q) |-> (out_len_q > LEN_W'(1) && !out_bad_q))
		else $error("cut-short character with length one");

	// a last-byte word leaves the decoder at a clean string start
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_chan.last_byte) |=>
		(left_q == '0 && char_cnt_q == '0 && byte_pos_q == '0))
		else $error("state not cleared after last byte");

	// an empty result register never blocks the byte side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> byte_chan.ready)
		else $error("byte side stalled with empty result register");

endmodule
